// ===== design/optt_pkg.sv =====
// Shared types and constants for the one-shot and periodic timer table.
package optt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int ID_W            = 31;
    localparam int TIME_W          = 64;
    localparam int DELAY_W         = 32;

    localparam logic [ID_W-1:0] ID_MAX   = {ID_W{1'b1}};
    localparam logic [ID_W-1:0] ID_FIRST = {{(ID_W-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {
        REQ_SET     = 2'd0,
        REQ_CLEAR   = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_UNKNOWN = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        RESP_SET_DONE   = 2'd0,
        RESP_CLEAR_DONE = 2'd1,
        RESP_FIRED      = 2'd2,
        RESP_TICK_DONE  = 2'd3
    } resp_kind_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [DELAY_W-1:0] delay_ticks;
        logic               periodic;
        logic [ID_W-1:0]    target_id;
    } req_word_t;

    typedef struct packed {
        logic [1:0]      resp_kind;
        logic [ID_W-1:0] result_id;
        logic            status;
        logic            pending;
        logic            last;
    } resp_word_t;

    typedef struct packed {
        logic              used;
        logic              cancelled;
        logic              repeats;
        logic [ID_W-1:0]   ident;
        logic [ID_W-1:0]   period;
        logic [TIME_W-1:0] deadline;
    } entry_t;

endpackage

// ===== design/optt_cell.sv =====
// One timer cell of the age-ordered chain.
module optt_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  optt_pkg::cell_op_t op,
    input  optt_pkg::entry_t  prev_entry,
    input  optt_pkg::entry_t  next_entry,
    input  logic              all_used_in,
    output logic              all_used_out,
    output optt_pkg::entry_t  entry
);
    import optt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   load;

    // An insert ripples through the unbroken run of used cells at the head and into the first free cell.
    always_comb
    begin
        load       = 1'b0;
        entry_next = entry_reg;
        unique case (op)
            CELL_INSERT:
            begin
                load       = all_used_in;
                entry_next = prev_entry;
            end
            CELL_ROTATE:
            begin
                load       = 1'b1;
                entry_next = next_entry;
            end
            default:
            begin
                load       = 1'b0;
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (load)
        begin
            entry_reg <= entry_next;
        end
    end

    assign all_used_out = all_used_in & entry_reg.used;
    assign entry        = entry_reg;

endmodule

// ===== design/oneshot_periodic_timer_table_top.sv =====
// Top level of the timer table: request decode, walk sequencer and the cell chain.
//
// The block takes request words on the req channel (set, clear or tick) and
// answers on the resp channel, both with valid/ready handshakes. Every request
// but an unknown one ends in exactly one word with last set; a tick may first
// give one fired word per expiring timer, newest timer first.
// Timers live in a row of TIMER_SLOTS cells kept in age order, newest at cell
// 0. A set is handled in the cycle it is accepted: its answer word is valid on
// the next cycle. A clear or a tick rotates the row once through the head
// processing stage, one cell per cycle unless the walk is held for a stalled
// fired word, with the 64-bit deadline compare at the head, and then issues the
// done word. A new request is taken once the previous one is finished and its
// last word has been taken or is being taken, so clears and ticks never overlap.
// When the receiver stalls, the rotation waits at any cell that must produce a
// fired word, so no word is lost; the walk resumes as soon as the output
// register empties.
// After reset the table is empty, time is zero and the first id issued is one.
module oneshot_periodic_timer_table_top
#(
    parameter int TIMER_SLOTS = optt_pkg::TIMER_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  optt_pkg::req_word_t req,
    output logic                resp_valid,
    input  logic                resp_ready,
    output optt_pkg::resp_word_t resp
);
    import optt_pkg::*;

    localparam int CW = $clog2(TIMER_SLOTS);
    localparam logic [CW-1:0] STEP_LAST = CW'(TIMER_SLOTS - 1);

    state_t           state_reg, state_next;
    logic [CW-1:0]    step_reg, step_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic             tick_reg, tick_next;
    logic [ID_W-1:0]  target_reg, target_next;
    logic             found_reg, found_next;
    logic             pend_reg, pend_next;
    logic             resp_valid_reg, resp_valid_next;
    resp_word_t       resp_reg, resp_next;

    entry_t           cell_q [TIMER_SLOTS];
    logic [TIMER_SLOTS:0] used_chain;
    cell_op_t         cell_op;
    entry_t           new_entry;
    entry_t           proc_entry;
    logic             table_full;
    logic             out_free;
    logic             req_fire;
    logic             fire_now;
    logic             advance;
    logic [ID_W-1:0]  delay_clamped;

    assign used_chain[0] = 1'b1;
    assign table_full    = used_chain[TIMER_SLOTS];

    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++)
        begin : g_cell
            optt_cell u_cell
            (
                .clk          (clk),
                .rst_n        (rst_n),
                .op           (cell_op),
                .prev_entry   ((g == 0) ? new_entry : cell_q[(g == 0) ? 0 : g - 1]),
                .next_entry   ((g == TIMER_SLOTS - 1) ? proc_entry
                               : cell_q[(g == TIMER_SLOTS - 1) ? g : g + 1]),
                .all_used_in  (used_chain[g]),
                .all_used_out (used_chain[g+1]),
                .entry        (cell_q[g])
            );
        end
    endgenerate

    assign out_free = !resp_valid_reg || resp_ready;
    assign req_fire = req_valid && req_ready;

    // A negative delay is treated as zero.
    assign delay_clamped = req.delay_ticks[DELAY_W-1] ? '0 : req.delay_ticks[ID_W-1:0];

    always_comb
    begin
        new_entry           = '0;
        new_entry.used      = 1'b1;
        new_entry.cancelled = 1'b0;
        new_entry.repeats   = req.periodic;
        new_entry.ident     = id_reg;
        new_entry.period    = delay_clamped;
        new_entry.deadline  = now_reg + {{(TIME_W-ID_W){1'b0}}, delay_clamped};
    end

    // Head processing stage: the entry leaving cell 0 is updated and fed to the tail.
    always_comb
    begin
        proc_entry = cell_q[0];
        fire_now   = 1'b0;
        found_next = found_reg;
        if (tick_reg)
        begin
            if (cell_q[0].used && cell_q[0].cancelled)
            begin
                proc_entry.used      = 1'b0;
                proc_entry.cancelled = 1'b0;
            end
            else if (cell_q[0].used && (now_reg >= cell_q[0].deadline))
            begin
                fire_now = 1'b1;
                if (cell_q[0].repeats)
                begin
                    proc_entry.deadline =
                        now_reg + {{(TIME_W-ID_W){1'b0}}, cell_q[0].period};
                end
                else
                begin
                    proc_entry.cancelled = 1'b1;
                end
            end
        end
        else if (!found_reg && cell_q[0].used && (cell_q[0].ident == target_reg))
        begin
            proc_entry.cancelled = 1'b1;
            found_next           = 1'b1;
        end
    end

    assign advance = !fire_now || out_free;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && ((req.req_type == REQ_CLEAR) || (req.req_type == REQ_TICK)))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (advance && (step_reg == STEP_LAST))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and datapath control of the sequencer.
    always_comb
    begin
        req_ready       = 1'b0;
        cell_op         = CELL_HOLD;
        step_next       = step_reg;
        now_next        = now_reg;
        id_next         = id_reg;
        tick_next       = tick_reg;
        target_next     = target_reg;
        pend_next       = pend_reg;
        resp_valid_next = resp_valid_reg && !resp_ready;
        resp_next       = resp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = out_free;
                step_next = '0;
                if (req_fire)
                begin
                    tick_next   = (req.req_type == REQ_TICK);
                    target_next = req.target_id;
                    pend_next   = 1'b0;
                    if (req.req_type == REQ_TICK)
                    begin
                        now_next = now_reg + {{(TIME_W-1){1'b0}}, 1'b1};
                    end
                    if (req.req_type == REQ_SET)
                    begin
                        resp_valid_next    = 1'b1;
                        resp_next          = '0;
                        resp_next.resp_kind = RESP_SET_DONE;
                        resp_next.last     = 1'b1;
                        if (table_full)
                        begin
                            resp_next.status = 1'b1;
                        end
                        else
                        begin
                            resp_next.result_id = id_reg;
                            cell_op             = CELL_INSERT;
                            id_next = (id_reg == ID_MAX) ? ID_FIRST : id_reg + ID_FIRST;
                        end
                    end
                end
            end
            ST_WALK:
            begin
                if (advance)
                begin
                    cell_op   = CELL_ROTATE;
                    step_next = (step_reg == STEP_LAST) ? '0 : step_reg + CW'(1);
                    if (proc_entry.used && !proc_entry.cancelled)
                    begin
                        pend_next = 1'b1;
                    end
                    if (fire_now)
                    begin
                        resp_valid_next     = 1'b1;
                        resp_next           = '0;
                        resp_next.resp_kind = RESP_FIRED;
                        resp_next.result_id = cell_q[0].ident;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    resp_valid_next     = 1'b1;
                    resp_next           = '0;
                    resp_next.resp_kind = tick_reg ? RESP_TICK_DONE : RESP_CLEAR_DONE;
                    resp_next.pending   = tick_reg && pend_reg;
                    resp_next.last      = 1'b1;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            now_reg        <= '0;
            id_reg         <= ID_FIRST;
            resp_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            now_reg        <= now_next;
            id_reg         <= id_next;
            resp_valid_reg <= resp_valid_next;
            if (req_fire)
            begin
                found_reg <= 1'b0;
            end
            else if (state_reg == ST_WALK && advance)
            begin
                found_reg <= found_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg   <= tick_next;
        target_reg <= target_next;
        pend_reg   <= pend_next;
        resp_reg   <= resp_next;
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

    // Nothing new is taken while a walk or its done word is outstanding.
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req_ready)
        else $error("request taken during a walk");

    // The step counter is parked at zero between requests.
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (step_reg == '0))
        else $error("step counter not parked");

    // A set into a table with room lands in the head cell.
    a_set_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.req_type == REQ_SET) && !table_full)
        |=> (cell_q[0].used && !cell_q[0].cancelled))
        else $error("set did not land at the head");

    // A tick advances time by exactly one.
    a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.req_type == REQ_TICK))
        |=> (now_reg == $past(now_reg) + {{(TIME_W-1){1'b0}}, 1'b1}))
        else $error("time did not advance on tick");

endmodule

// ===== verif/oneshot_periodic_timer_table_top_tb.sv =====
// Self-checking testbench for the one-shot and periodic timer table top level.
module oneshot_periodic_timer_table_top_tb;
    import optt_pkg::*;

    localparam int  SLOTS       = TIMER_SLOTS_DEF;
    localparam int  RAND_ITEMS  = 400;
    localparam int  CYCLE_LIMIT = 600000;

    // Clock, reset and the two channels of the block.
    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_word_t  req;
    logic       resp_valid;
    logic       resp_ready;
    resp_word_t resp;

    oneshot_periodic_timer_table_top #(.TIMER_SLOTS(SLOTS)) dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    // Words waiting to be offered, and answers the table model says must come back.
    req_word_t  req_backlog[$];
    resp_word_t answers_due[$];

    int idle_pct;
    int stall_pct;
    int fail_count;
    int cycle_count;
    int sets_done;
    int sets_refused;
    int fires_seen;
    int ticks_done;
    int clears_done;

    // Shadow copy of the timer table, kept in step with every accepted word.
    logic              tab_used      [SLOTS];
    logic              tab_cancelled [SLOTS];
    logic              tab_repeats   [SLOTS];
    logic [ID_W-1:0]   tab_ident     [SLOTS];
    logic [ID_W-1:0]   tab_period    [SLOTS];
    logic [TIME_W-1:0] tab_deadline  [SLOTS];
    int                tab_rank      [SLOTS];
    logic [TIME_W-1:0] now_ticks;
    logic [ID_W-1:0]   next_ident;

    always #5 clk = ~clk;

    function automatic resp_word_t answer(resp_kind_t kind, logic [ID_W-1:0] id,
                                          logic st, logic pend, logic lst);
        resp_word_t a;
        a.resp_kind = kind;
        a.result_id = id;
        a.status    = st;
        a.pending   = pend;
        a.last      = lst;
        return a;
    endfunction

    // Slots in use, newest first; returns how many there are.
    function automatic int newest_first(output int order[SLOTS]);
        int n;
        n = 0;
        for (int r = 0; r < SLOTS; r++)
            for (int s = 0; s < SLOTS; s++)
                if (tab_used[s] && tab_rank[s] == r)
                begin
                    order[n++] = s;
                    break;
                end
        return n;
    endfunction

    // Apply one accepted request word to the shadow table and queue its answers.
    task automatic apply_request(req_word_t w);
        int               order[SLOTS];
        int               n;
        int               free_slot;
        int               rank;
        logic             pend;
        logic [ID_W-1:0]  delay;
        free_slot = -1;
        rank      = 0;
        pend      = 1'b0;
        case (req_kind_t'(w.req_type))
            REQ_SET:
            begin
                for (int s = SLOTS - 1; s >= 0; s--)
                    if (!tab_used[s])
                        free_slot = s;
                if (free_slot < 0)
                begin
                    answers_due.push_back(answer(RESP_SET_DONE, '0, 1'b1, 1'b0, 1'b1));
                    sets_refused++;
                end
                else
                begin
                    // A negative delay counts as zero.
                    delay = w.delay_ticks[DELAY_W-1] ? '0 : w.delay_ticks[ID_W-1:0];
                    for (int s = 0; s < SLOTS; s++)
                        if (tab_used[s])
                            tab_rank[s]++;
                    tab_used[free_slot]      = 1'b1;
                    tab_cancelled[free_slot] = 1'b0;
                    tab_repeats[free_slot]   = w.periodic;
                    tab_ident[free_slot]     = next_ident;
                    tab_period[free_slot]    = delay;
                    tab_deadline[free_slot]  = now_ticks + TIME_W'(delay);
                    tab_rank[free_slot]      = 0;
                    answers_due.push_back(answer(RESP_SET_DONE, next_ident, 1'b0, 1'b0, 1'b1));
                    // Ids wrap back to one, never to zero.
                    next_ident = (next_ident == ID_MAX) ? ID_FIRST : next_ident + 1'b1;
                    sets_done++;
                end
            end
            REQ_CLEAR:
            begin
                n = newest_first(order);
                for (int i = 0; i < n; i++)
                    if (tab_ident[order[i]] == w.target_id)
                    begin
                        tab_cancelled[order[i]] = 1'b1;
                        break;
                    end
                answers_due.push_back(answer(RESP_CLEAR_DONE, '0, 1'b0, 1'b0, 1'b1));
                clears_done++;
            end
            REQ_TICK:
            begin
                now_ticks = now_ticks + 1'b1;
                n = newest_first(order);
                for (int i = 0; i < n; i++)
                begin
                    if (tab_cancelled[order[i]])
                    begin
                        tab_used[order[i]]      = 1'b0;
                        tab_cancelled[order[i]] = 1'b0;
                    end
                    else if (now_ticks >= tab_deadline[order[i]])
                    begin
                        answers_due.push_back(answer(RESP_FIRED, tab_ident[order[i]],
                                                     1'b0, 1'b0, 1'b0));
                        fires_seen++;
                        if (tab_repeats[order[i]])
                            tab_deadline[order[i]] = now_ticks + TIME_W'(tab_period[order[i]]);
                        else
                            tab_cancelled[order[i]] = 1'b1;
                    end
                end
                for (int i = 0; i < n; i++)
                    if (tab_used[order[i]])
                    begin
                        tab_rank[order[i]] = rank++;
                        if (!tab_cancelled[order[i]])
                            pend = 1'b1;
                    end
                answers_due.push_back(answer(RESP_TICK_DONE, '0, 1'b0, pend, 1'b1));
                ticks_done++;
            end
            default: ;  // An unknown request is dropped without an answer.
        endcase
    endtask

    function automatic req_word_t make_word(req_kind_t kind, logic [DELAY_W-1:0] delay,
                                            logic per, logic [ID_W-1:0] target);
        req_word_t w;
        w.req_type    = kind;
        w.delay_ticks = delay;
        w.periodic    = per;
        w.target_id   = target;
        return w;
    endfunction

    // One random request. Sets mostly use short delays so that timers really
    // fire; clears mostly aim at ids handed out recently so that they hit.
    function automatic req_word_t random_word(logic [ID_W-1:0] recent_id);
        int pick;
        logic [DELAY_W-1:0] delay;
        logic [ID_W-1:0]    target;
        pick = $urandom_range(99);
        if (pick < 8)
            delay = $urandom;
        else
            delay = $urandom_range(12);
        if ($urandom_range(3) == 0)
            target = ID_W'({$urandom} >> 1);
        else
            target = recent_id - ID_W'($urandom_range(6));
        pick = $urandom_range(99);
        if (pick < 38)
            return make_word(REQ_SET, delay, 1'($urandom_range(1)), ID_W'({$urandom} >> 1));
        else if (pick < 58)
            return make_word(REQ_CLEAR, $urandom, 1'($urandom_range(1)), target);
        else if (pick < 96)
            return make_word(REQ_TICK, $urandom, 1'($urandom_range(1)),
                             ID_W'({$urandom} >> 1));
        else
            return make_word(REQ_UNKNOWN, $urandom, 1'($urandom_range(1)),
                             ID_W'({$urandom} >> 1));
    endfunction

    // Driver: the model is updated on acceptance, then the next word (or a
    // gap) is put on the channel. Valid is only dropped once a word is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                apply_request(req);
            if (!req_valid || req_ready)
            begin
                if (req_backlog.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    req       <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Monitor: every word taken from the block is checked against the oldest
    // answer due, field by field; the receiver stalls at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (resp_valid && resp_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("unexpected answer word kind=%0d id=%0d", resp.resp_kind,
                           resp.result_id);
                    fail_count++;
                end
                else
                begin
                    automatic resp_word_t due = answers_due.pop_front();
                    if (resp.resp_kind !== due.resp_kind)
                    begin
                        $error("resp_kind: expected %0d, got %0d", due.resp_kind,
                               resp.resp_kind);
                        fail_count++;
                    end
                    if (resp.result_id !== due.result_id)
                    begin
                        $error("result_id: expected %0d, got %0d", due.result_id,
                               resp.result_id);
                        fail_count++;
                    end
                    if (resp.status !== due.status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, resp.status);
                        fail_count++;
                    end
                    if (resp.pending !== due.pending)
                    begin
                        $error("pending: expected %0d, got %0d", due.pending, resp.pending);
                        fail_count++;
                    end
                    if (resp.last !== due.last)
                    begin
                        $error("last: expected %0d, got %0d", due.last, resp.last);
                        fail_count++;
                    end
                end
            end
            resp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Wait until every queued word has been taken and every answer has come.
    task automatic drain();
        wait (req_backlog.size() == 0 && !req_valid);
        wait (answers_due.size() == 0);
        @(posedge clk);
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        resp_ready   = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        fail_count   = 0;
        cycle_count  = 0;
        sets_done    = 0;
        sets_refused = 0;
        fires_seen   = 0;
        ticks_done   = 0;
        clears_done  = 0;
        for (int s = 0; s < SLOTS; s++)
        begin
            tab_used[s]      = 1'b0;
            tab_cancelled[s] = 1'b0;
            tab_repeats[s]   = 1'b0;
            tab_ident[s]     = '0;
            tab_period[s]    = '0;
            tab_deadline[s]  = '0;
            tab_rank[s]      = 0;
        end
        now_ticks  = '0;
        next_ident = ID_FIRST;

        // Directed opening: zero delays of both kinds, the most negative and the
        // largest delay, clears of id zero, of an unknown id and of a live timer,
        // an unknown request, then fourteen sets that fill all slots but one.
        req_backlog.push_back(make_word(REQ_SET, 32'd0, 1'b0, '0));
        req_backlog.push_back(make_word(REQ_SET, 32'd0, 1'b1, ID_MAX));
        req_backlog.push_back(make_word(REQ_SET, 32'h8000_0000, 1'b0, '0));
        req_backlog.push_back(make_word(REQ_SET, 32'h7FFF_FFFF, 1'b1, '0));
        req_backlog.push_back(make_word(REQ_CLEAR, 32'hFFFF_FFFF, 1'b1, '0));
        req_backlog.push_back(make_word(REQ_CLEAR, '0, 1'b0, ID_MAX));
        req_backlog.push_back(make_word(REQ_UNKNOWN, 32'hFFFF_FFFF, 1'b1, ID_MAX));
        req_backlog.push_back(make_word(REQ_TICK, '0, 1'b0, '0));
        req_backlog.push_back(make_word(REQ_TICK, '0, 1'b0, '0));
        req_backlog.push_back(make_word(REQ_CLEAR, '0, 1'b0, 31'd2));
        req_backlog.push_back(make_word(REQ_TICK, '0, 1'b0, '0));
        for (int i = 0; i < 14; i++)
            req_backlog.push_back(make_word(REQ_SET, 32'd5 + i, i[0], '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        drain();

        // Four random phases with different idling, each starting from a quiet
        // block: free running, a lazy sender, a stalling receiver, then both.
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 24 : 62) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 24 : 62) : 0;
            for (int i = 0; i < RAND_ITEMS / 4; i++)
            begin
                req_backlog.push_back(random_word(next_ident - 1'b1));
                // Keep the backlog short so clears see fresh ids.
                wait (req_backlog.size() < 2);
            end
            drain();
        end

        repeat (2 * SLOTS + 20) @(posedge clk);
        $display("Covered %0d sets (%0d refused as full), %0d clears, %0d ticks, %0d fires.",
                 sets_done, sets_refused, clears_done, ticks_done, fires_seen);
        $display("Idling phases: none, sender only, receiver only, and both.");
        if (fail_count == 0 && answers_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
design/optt_pkg.sv
design/optt_cell.sv
design/oneshot_periodic_timer_table_top.sv
verif/oneshot_periodic_timer_table_top_tb.sv
